### rtl/pn_pkg.sv
package pn_pkg;

  localparam int unsigned MaxPath       = 1024;
  localparam int unsigned MaxComponents = 512;
  localparam int unsigned LenW          = 10;
  localparam int unsigned CapW          = 11;
  localparam int unsigned BankCnt       = 4;
  localparam int unsigned BankSelW      = $clog2(BankCnt);
  localparam int unsigned BankDepth     = MaxPath / BankCnt;
  localparam int unsigned BankAw        = $clog2(BankDepth);
  localparam int unsigned StackAw       = $clog2(MaxComponents);

  typedef logic [7:0]      byte_t;
  typedef logic [LenW-1:0] len_t;
  typedef logic [CapW-1:0] cap_t;

  localparam cap_t  CapacityReset = cap_t'(1024);
  localparam byte_t CharNul       = 8'h00;
  localparam byte_t CharSlash     = 8'h2F;
  localparam byte_t CharDot       = 8'h2E;

  typedef enum logic [1:0] {
    LEAD_START,
    LEAD_ONE,
    LEAD_BODY,
    LEAD_CLOSED
  } lead_e;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_READ = 1'b1
  } mode_e;

endpackage

### rtl/pn_if.sv
interface pn_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  pn_pkg::byte_t      path_byte;
  logic               last_byte;
  pn_pkg::len_t       read_index;

  modport source (output valid, mode, path_byte, last_byte, read_index, input ready);
  modport sink   (input valid, mode, path_byte, last_byte, read_index, output ready);
endinterface

interface pn_out_if;
  logic               valid;
  logic               ready;
  pn_pkg::byte_t      out_byte;
  pn_pkg::len_t       length;
  logic               too_big;
  logic               done_res;

  modport source (output valid, out_byte, length, too_big, done_res, input ready);
  modport sink   (input valid, out_byte, length, too_big, done_res, output ready);
endinterface

interface pn_cfg_if;
  logic               valid;
  logic               ready;
  pn_pkg::cap_t       capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

### rtl/pn_ram.sv
module pn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/path_normalizer.sv
// Streaming Unix path cleaner.
// Items arrive on in_i with a valid/ready handshake. A push item (mode 0) feeds one
// path byte; the path ends at a NUL byte or at an item with last_byte set, and the
// next push after last_byte starts a new path. A read item (mode 1) returns the
// cleaned byte at read_index and leaves the path state alone.
// Every item yields exactly one result on out_o: out_byte (zero for pushes), the
// current cleaned length, the sticky too_big flag and done_res.
// The result buffer size is written on cfg_i; the user must write it only while the
// block is idle, as the block itself does not enforce this. cfg_i is always ready.
// A result is valid in the cycle after its item is accepted, and one item is taken
// in every cycle while out_o does not stall. The cleaned bytes live in four
// interleaved byte banks so that the up to four bytes a single item can emit are
// written in the same cycle; the component start stack is a memory with one write
// and one read port, and its top entry is held in a register.
// When out_o stalls, the result register holds its item and in_i.ready drops
// until the result is taken; a result taken in a cycle frees room for a new item
// in that same cycle.
// Reset clears the path state and sets capacity to 1024. The contents of the
// result buffer are undefined until written; there is no clearing pass.
module path_normalizer (
  input  logic  clk_i,
  input  logic  rst_ni,
  pn_in_if.sink     in_i,
  pn_out_if.source  out_o,
  pn_cfg_if.sink    cfg_i
);

  localparam int unsigned LenW    = pn_pkg::LenW;
  localparam int unsigned StackAw = pn_pkg::StackAw;
  localparam int unsigned BankCnt = pn_pkg::BankCnt;
  localparam int unsigned SelW    = pn_pkg::BankSelW;
  localparam int unsigned BankAw  = pn_pkg::BankAw;

  pn_pkg::cap_t  cap_q;
  pn_pkg::len_t  len_q, len_d;
  pn_pkg::len_t  kc_q, kc_d;
  pn_pkg::len_t  cs_q, cs_d;
  logic [1:0]    cl_q, cl_d;
  logic          ad_q, ad_d;
  logic          sep_q, sep_d;
  pn_pkg::lead_e lead_q, lead_d;
  logic          err_q, err_d;
  logic          ended_q, ended_d;
  pn_pkg::len_t  top_q, top_d;
  logic          top_ram_q, top_ram_d;

  logic          ovalid_q;
  logic          o_rd_q;
  logic [SelW-1:0] o_sel_q;
  pn_pkg::len_t  o_len_q;
  logic          o_err_q;
  logic          o_done_q;

  logic          accept, commit, is_read;

  pn_pkg::len_t  len0, kc0, cs0, cs1, len1, lim, room, kc_m2, top_val;
  pn_pkg::cap_t  capm1;
  logic [1:0]    cl0, cl1, idx;
  logic          ad0, ad1, sep0, sep1, err0, end0;
  pn_pkg::lead_e lead0, lead1;
  pn_pkg::byte_t ch;
  logic          is_nul, is_slash, is_dot, feed_en, body, body_slash;
  logic [3:0][7:0] seq;
  logic [2:0]    nf, n, w;
  logic          err_put, end_pre, end_post, dotdot, do_push, end_write;
  logic          do_pop, push_ok, push_full;

  logic [BankCnt-1:0]             bank_we;
  logic [BankCnt-1:0][BankAw-1:0] bank_waddr;
  logic [BankCnt-1:0][7:0]        bank_wdata;
  logic [BankCnt-1:0][7:0]        bank_rdata;
  pn_pkg::len_t                   stack_rdata;

  assign accept  = in_i.valid && in_i.ready;
  assign is_read = (in_i.mode == pn_pkg::MODE_READ);
  assign commit  = accept && !is_read;

  assign in_i.ready  = !ovalid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    len0  = len_q;
    kc0   = kc_q;
    cs0   = cs_q;
    cl0   = cl_q;
    ad0   = ad_q;
    sep0  = sep_q;
    lead0 = lead_q;
    err0  = err_q;
    end0  = ended_q;
    if (lead_q == pn_pkg::LEAD_CLOSED) begin
      len0  = '0;
      kc0   = '0;
      cs0   = '0;
      cl0   = '0;
      ad0   = 1'b0;
      sep0  = 1'b0;
      lead0 = pn_pkg::LEAD_START;
      err0  = 1'b0;
      end0  = 1'b0;
    end

    ch       = in_i.path_byte;
    is_nul   = (ch == pn_pkg::CharNul);
    is_slash = (ch == pn_pkg::CharSlash);
    is_dot   = (ch == pn_pkg::CharDot);
    feed_en  = !end0 && !is_nul && !err0;

    cs1        = cs0;
    cl1        = cl0;
    ad1        = ad0;
    sep1       = sep0;
    lead1      = lead0;
    body       = 1'b0;
    body_slash = 1'b0;
    nf         = '0;
    idx        = '0;
    seq        = {4{pn_pkg::CharDot}};

    if (feed_en) begin
      unique case (lead0)
        pn_pkg::LEAD_START: begin
          if (is_slash) begin
            sep1  = 1'b1;
            lead1 = pn_pkg::LEAD_ONE;
          end else begin
            lead1 = pn_pkg::LEAD_BODY;
            body  = 1'b1;
          end
        end
        pn_pkg::LEAD_ONE: begin
          lead1 = pn_pkg::LEAD_BODY;
          if (is_slash) begin
            seq[0] = pn_pkg::CharSlash;
            nf     = 3'd1;
          end else begin
            body = 1'b1;
          end
        end
        default: begin
          body = 1'b1;
        end
      endcase

      if (body) begin
        if (is_slash) begin
          body_slash = 1'b1;
        end else if (cl0 == 2'd0) begin
          cs1  = len0;
          cl1  = 2'd1;
          if (is_dot) begin
            ad1 = 1'b1;
          end else begin
            ad1      = 1'b0;
            sep1     = 1'b1;
            idx      = {1'b0, sep0};
            seq[0]   = sep0 ? pn_pkg::CharSlash : pn_pkg::CharDot;
            seq[idx] = ch;
            nf       = {1'b0, idx} + 3'd1;
          end
        end else if (ad0) begin
          if (is_dot && cl0 == 2'd1) begin
            cl1 = 2'd2;
          end else begin
            ad1      = 1'b0;
            sep1     = 1'b1;
            cl1      = (cl0 == 2'd1) ? 2'd2 : 2'd3;
            idx      = {1'b0, sep0} + cl0;
            seq[0]   = sep0 ? pn_pkg::CharSlash : pn_pkg::CharDot;
            seq[idx] = ch;
            nf       = {1'b0, idx} + 3'd1;
          end
        end else begin
          seq[0] = ch;
          nf     = 3'd1;
          cl1    = (cl0 == 2'd3) ? 2'd3 : cl0 + 2'd1;
        end
      end
    end

    // Closing a component: the only case that writes is a leading '..'.
    end_pre   = !end0 && !err0 && (body_slash || is_nul || in_i.last_byte);
    dotdot    = ad1 && (cl1 == 2'd2);
    do_push   = (cl1 != 2'd0) && !(ad1 && (cl1 == 2'd1 || cl1 == 2'd2));
    end_write = end_pre && dotdot && (kc0 == '0);

    n = nf;
    if (end_write) begin
      seq    = {4{pn_pkg::CharDot}};
      seq[0] = sep1 ? pn_pkg::CharSlash : pn_pkg::CharDot;
      n      = 3'd2 + {2'b0, sep1};
    end

    capm1 = cap_q - pn_pkg::cap_t'(1);
    if (cap_q == '0) begin
      lim = '0;
    end else if (capm1 > pn_pkg::cap_t'(pn_pkg::MaxPath - 1)) begin
      lim = LenW'(pn_pkg::MaxPath - 1);
    end else begin
      lim = capm1[LenW-1:0];
    end
    room    = (len0 < lim) ? lim - len0 : '0;
    w       = ({{(LenW-3){1'b0}}, n} < room) ? n : room[2:0];
    len1    = len0 + {{(LenW-3){1'b0}}, w};
    err_put = (n != 3'd0) && (len1 >= lim);

    end_post  = end_pre && !((nf != 3'd0) && err_put);
    top_val   = top_ram_q ? stack_rdata : top_q;
    do_pop    = end_post && dotdot && (kc0 != '0);
    push_full = end_post && do_push && (kc0 >= LenW'(pn_pkg::MaxComponents));
    push_ok   = end_post && do_push && !push_full;
    kc_m2     = kc0 - LenW'(2);

    len_d     = do_pop ? top_val : len1;
    kc_d      = kc0;
    top_d     = top_q;
    top_ram_d = top_ram_q;
    if (do_pop) begin
      kc_d      = kc0 - LenW'(1);
      top_ram_d = 1'b1;
    end else if (push_ok) begin
      kc_d      = kc0 + LenW'(1);
      top_d     = cs1;
      top_ram_d = 1'b0;
    end
    cs_d    = cs1;
    cl_d    = end_post ? 2'd0 : cl1;
    ad_d    = end_post ? 1'b0 : ad1;
    sep_d   = sep1 | end_write;
    err_d   = err0 | err_put | push_full;
    ended_d = end0 | is_nul | in_i.last_byte;
    lead_d  = in_i.last_byte ? pn_pkg::LEAD_CLOSED : lead1;
  end

  always_comb begin
    logic [SelW-1:0] jb;
    pn_pkg::len_t    ab;
    for (int b = 0; b < BankCnt; b++) begin
      jb            = SelW'(b) - len0[SelW-1:0];
      ab            = len0 + {{(LenW-SelW){1'b0}}, jb};
      bank_we[b]    = commit && ({1'b0, jb} < w);
      bank_waddr[b] = ab[LenW-1:SelW];
      bank_wdata[b] = seq[jb];
    end
  end

  for (genvar b = 0; b < BankCnt; b++) begin : g_bank
    pn_ram #(
      .Width (8),
      .Depth (pn_pkg::BankDepth)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (bank_waddr[b]),
      .wdata_i (bank_wdata[b]),
      .re_i    (accept && is_read),
      .raddr_i (in_i.read_index[LenW-1:SelW]),
      .rdata_o (bank_rdata[b])
    );
  end

  pn_ram #(
    .Width (LenW),
    .Depth (pn_pkg::MaxComponents)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (commit && push_ok),
    .waddr_i (kc0[StackAw-1:0]),
    .wdata_i (cs1),
    .re_i    (commit && do_pop && (kc0 >= LenW'(2))),
    .raddr_i (kc_m2[StackAw-1:0]),
    .rdata_o (stack_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= pn_pkg::CapacityReset;
      len_q     <= '0;
      kc_q      <= '0;
      cs_q      <= '0;
      cl_q      <= '0;
      ad_q      <= 1'b0;
      sep_q     <= 1'b0;
      lead_q    <= pn_pkg::LEAD_START;
      err_q     <= 1'b0;
      ended_q   <= 1'b0;
      top_ram_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        cap_q <= cfg_i.capacity;
      end
      if (commit) begin
        len_q     <= len_d;
        kc_q      <= kc_d;
        cs_q      <= cs_d;
        cl_q      <= cl_d;
        ad_q      <= ad_d;
        sep_q     <= sep_d;
        lead_q    <= lead_d;
        err_q     <= err_d;
        ended_q   <= ended_d;
        top_ram_q <= top_ram_d;
      end
      if (accept) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      top_q <= top_d;
    end
    if (accept) begin
      o_rd_q   <= is_read;
      o_sel_q  <= in_i.read_index[SelW-1:0];
      o_len_q  <= is_read ? len_q : len_d;
      o_err_q  <= is_read ? err_q : err_d;
      o_done_q <= is_read ? ended_q : ended_d;
    end
  end

  assign out_o.valid    = ovalid_q;
  assign out_o.out_byte = o_rd_q ? bank_rdata[o_sel_q] : '0;
  assign out_o.length   = o_len_q;
  assign out_o.too_big  = o_err_q;
  assign out_o.done_res = o_done_q;

endmodule
